>>> src/crre_pkg.sv
package crre_pkg;

   // Command codes carried on req_command.
   localparam logic [2:0] CMD_SET = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_INT = 3'd2;
   localparam logic [2:0] CMD_OVL = 3'd3;
   localparam logic [2:0] CMD_RDE = 3'd4;

   // Commands from the controller to the datapath, one per step that acts on the datapath.
   typedef struct packed {
      logic load;
      logic set_wr;
      logic ovl_rd;
      logic ovl_chk;
      logic rde_rd;
      logic rde_ld;
      logic src_rd;
      logic src_ld;
      logic cut_step;
      logic pc_next;
      logic add_rd;
      logic add_cmp;
      logic commit;
      logic respond;
   } ctl_cmd_type;

   // Status from the datapath that steers the controller.
   typedef struct packed {
      logic cmd_set;
      logic cmd_bld;
      logic cmd_ovl;
      logic cmd_rde;
      logic is_sub;
      logic ovl_end;
      logic rd_hit;
      logic idx_ok;
      logic src_end;
      logic cut_last;
      logic pc_end;
      logic add_scan;
      logic add_full;
      logic merge_hit;
   } ctl_sts_type;

endpackage

>>> src/clip_region_rect_engine_top.sv
// Clip region engine: keeps a region as a list of inclusive rectangles.
// Command channel: drive req_* and raise start; a beat is taken at the edge
// where start is high and busy is low. busy stays high until the result.
// Result channel: rsp_valid is high for exactly one cycle with the rsp_*
// fields; the receiver cannot stall it and must take the beat then.
// Steps from accept to result, with W the merge window:
//   unused codes: dispatch only; set: a table write; read: an entry read if in range.
//   overlap test: a read and a check per rectangle scanned; a hit ends the scan.
//   intersect: per rectangle a read and, when it overlaps, a scan of up to W entries.
//   subtract: per rectangle up to four cut steps, then a scan per piece (up to four).
// Each window compare takes a read step and then a compare step.
// One command runs at a time.
// Reset empties the region at once; table contents are not cleared.
// A capacity overflow ends the walk, returns status 1 and keeps the region.
module clip_region_rect_engine_top
   import crre_pkg::*;
#(
   parameter int MAX_RECTS    = 64,
   parameter int MERGE_WINDOW = 5,
   parameter int COORD_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [2:0]                            req_command,
   input  logic signed [COORD_BITS-1:0]          req_x_left,
   input  logic signed [COORD_BITS-1:0]          req_y_top,
   input  logic signed [COORD_BITS-1:0]          req_x_right,
   input  logic signed [COORD_BITS-1:0]          req_y_bottom,
   input  logic [5:0]                            req_entry_index,
   output logic                                  rsp_valid,
   output logic                                  rsp_status,
   output logic                                  rsp_overlap_found,
   output logic                                  rsp_region_empty,
   output logic [$clog2(MAX_RECTS + 1)-1:0]      rsp_rect_count,
   output logic signed [COORD_BITS-1:0]          rsp_out_x_left,
   output logic signed [COORD_BITS-1:0]          rsp_out_y_top,
   output logic signed [COORD_BITS-1:0]          rsp_out_x_right,
   output logic signed [COORD_BITS-1:0]          rsp_out_y_bottom
);

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   // Sequencer.
   crre_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (ctl_sts),
      .cmd   (ctl_cmd)
   );

   // Tables, piece list and compare logic.
   crre_dpath #(
      .MAX_RECTS    (MAX_RECTS),
      .MERGE_WINDOW (MERGE_WINDOW),
      .COORD_BITS   (COORD_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctl_cmd),
      .sts               (ctl_sts),
      .req_command       (req_command),
      .req_x_left        (req_x_left),
      .req_y_top         (req_y_top),
      .req_x_right       (req_x_right),
      .req_y_bottom      (req_y_bottom),
      .req_entry_index   (req_entry_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_overlap_found (rsp_overlap_found),
      .rsp_region_empty  (rsp_region_empty),
      .rsp_rect_count    (rsp_rect_count),
      .rsp_out_x_left    (rsp_out_x_left),
      .rsp_out_y_top     (rsp_out_y_top),
      .rsp_out_x_right   (rsp_out_x_right),
      .rsp_out_y_bottom  (rsp_out_y_bottom)
   );

   // A result beat lasts one cycle and ends the command.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result beat longer than one cycle");

   // An accepted command keeps the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command accepted without going busy");

   // Results only come out of a running command.
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   // An overflow never goes with an overlap hit.
   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_status && rsp_overlap_found))
      else $error("overflow and overlap flagged together");

endmodule

>>> src/crre_ctrl.sv
module crre_ctrl
   import crre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_DISP    = 15'b000000000000010,
      ST_SET     = 15'b000000000000100,
      ST_OVL_RD  = 15'b000000000001000,
      ST_OVL_CHK = 15'b000000000010000,
      ST_RDE_RD  = 15'b000000000100000,
      ST_RDE_LD  = 15'b000000001000000,
      ST_SRC_RD  = 15'b000000010000000,
      ST_SRC_LD  = 15'b000000100000000,
      ST_CUT     = 15'b000001000000000,
      ST_PC_NEXT = 15'b000010000000000,
      ST_ADD_RD  = 15'b000100000000000,
      ST_ADD_CMP = 15'b001000000000000,
      ST_COMMIT  = 15'b010000000000000,
      ST_RESP    = 15'b100000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != ST_IDLE);

   // Next state and the datapath command for the current step.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            if (sts.cmd_set)      state_in = ST_SET;
            else if (sts.cmd_bld) state_in = ST_SRC_RD;
            else if (sts.cmd_ovl) state_in = ST_OVL_RD;
            else if (sts.cmd_rde) state_in = ST_RDE_RD;
            else                  state_in = ST_RESP;
         end
         ST_SET: begin
            cmd.set_wr = 1'b1;
            state_in   = ST_RESP;
         end
         ST_OVL_RD: begin
            if (sts.ovl_end) begin
               state_in = ST_RESP;
            end else begin
               cmd.ovl_rd = 1'b1;
               state_in   = ST_OVL_CHK;
            end
         end
         ST_OVL_CHK: begin
            cmd.ovl_chk = 1'b1;
            state_in    = sts.rd_hit ? ST_RESP : ST_OVL_RD;
         end
         ST_RDE_RD: begin
            if (sts.idx_ok) begin
               cmd.rde_rd = 1'b1;
               state_in   = ST_RDE_LD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RDE_LD: begin
            cmd.rde_ld = 1'b1;
            state_in   = ST_RESP;
         end
         ST_SRC_RD: begin
            if (sts.src_end) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.src_rd = 1'b1;
               state_in   = ST_SRC_LD;
            end
         end
         ST_SRC_LD: begin
            cmd.src_ld = 1'b1;
            if (sts.is_sub)      state_in = ST_CUT;
            else if (sts.rd_hit) state_in = ST_ADD_RD;
            else                 state_in = ST_SRC_RD;
         end
         ST_CUT: begin
            cmd.cut_step = 1'b1;
            if (sts.cut_last) state_in = ST_PC_NEXT;
         end
         ST_PC_NEXT: begin
            if (sts.pc_end) begin
               state_in = ST_SRC_RD;
            end else begin
               cmd.pc_next = 1'b1;
               state_in    = ST_ADD_RD;
            end
         end
         ST_ADD_RD: begin
            cmd.add_rd = 1'b1;
            if (sts.add_scan)      state_in = ST_ADD_CMP;
            else if (sts.add_full) state_in = ST_RESP;
            else                   state_in = sts.is_sub ? ST_PC_NEXT : ST_SRC_RD;
         end
         ST_ADD_CMP: begin
            cmd.add_cmp = 1'b1;
            if (sts.merge_hit) state_in = sts.is_sub ? ST_PC_NEXT : ST_SRC_RD;
            else               state_in = ST_ADD_RD;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> src/crre_dpath.sv
module crre_dpath
   import crre_pkg::*;
#(
   parameter int MAX_RECTS    = 64,
   parameter int MERGE_WINDOW = 5,
   parameter int COORD_BITS   = 16,
   localparam int CW          = $clog2(MAX_RECTS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_cmd_type                  cmd,
   output ctl_sts_type                  sts,
   input  logic [2:0]                   req_command,
   input  logic signed [COORD_BITS-1:0] req_x_left,
   input  logic signed [COORD_BITS-1:0] req_y_top,
   input  logic signed [COORD_BITS-1:0] req_x_right,
   input  logic signed [COORD_BITS-1:0] req_y_bottom,
   input  logic [5:0]                   req_entry_index,
   output logic                         rsp_valid,
   output logic                         rsp_status,
   output logic                         rsp_overlap_found,
   output logic                         rsp_region_empty,
   output logic [CW-1:0]                rsp_rect_count,
   output logic signed [COORD_BITS-1:0] rsp_out_x_left,
   output logic signed [COORD_BITS-1:0] rsp_out_y_top,
   output logic signed [COORD_BITS-1:0] rsp_out_x_right,
   output logic signed [COORD_BITS-1:0] rsp_out_y_bottom
);

   localparam int CB = COORD_BITS;
   localparam int RW = 4 * CB;
   localparam int AW = $clog2(MAX_RECTS);

   // A rectangle is packed as {y_bottom, x_right, y_top, x_left}.
   function automatic logic signed [CB-1:0] crd(input logic [RW-1:0] r, input int c);
      return r[c*CB +: CB];
   endfunction

   function automatic logic [RW-1:0] mk(input logic signed [CB-1:0] x0,
                                        input logic signed [CB-1:0] y0,
                                        input logic signed [CB-1:0] x1,
                                        input logic signed [CB-1:0] y1);
      return {y1, x1, y0, x0};
   endfunction

   function automatic logic overlaps(input logic [RW-1:0] d, input logic [RW-1:0] s);
      return (crd(s, 2) >= crd(d, 0)) && (crd(s, 0) <= crd(d, 2)) &&
             (crd(s, 3) >= crd(d, 1)) && (crd(s, 1) <= crd(d, 3));
   endfunction

   // True when a + 1 == b, computed one bit wider so it never wraps.
   function automatic logic adj(input logic signed [CB-1:0] a, input logic signed [CB-1:0] b);
      logic signed [CB:0] ae;
      logic signed [CB:0] be;
      ae = {a[CB-1], a};
      be = {b[CB-1], b};
      return (ae + (CB+1)'(1)) == be;
   endfunction

   // Merge candidate c into stored r; the top bit flags a merge.
   function automatic logic [RW:0] try_merge(input logic [RW-1:0] r, input logic [RW-1:0] c);
      logic [RW-1:0] m;
      logic          hit;
      m   = r;
      hit = 1'b0;
      if (crd(r, 1) == crd(c, 1) && crd(r, 3) == crd(c, 3)) begin
         if (adj(crd(r, 2), crd(c, 0))) begin
            m[2*CB +: CB] = crd(c, 2);
            hit = 1'b1;
         end else if (adj(crd(c, 2), crd(r, 0))) begin
            m[0 +: CB] = crd(c, 0);
            hit = 1'b1;
         end
      end else if (crd(r, 0) == crd(c, 0) && crd(r, 2) == crd(c, 2)) begin
         if (adj(crd(r, 3), crd(c, 1))) begin
            m[3*CB +: CB] = crd(c, 3);
            hit = 1'b1;
         end else if (adj(crd(c, 3), crd(r, 1))) begin
            m[CB +: CB] = crd(c, 1);
            hit = 1'b1;
         end
      end
      return {hit, m};
   endfunction

   // Two table banks; the active one holds the region, the other is built.
   logic [RW-1:0] bank0_ff [MAX_RECTS];
   logic [RW-1:0] bank1_ff [MAX_RECTS];
   logic [RW-1:0] rdata0_ff, rdata1_ff;
   logic          rdsel_ff;

   logic          mem_re, mem_rbank, mem_we, mem_wbank;
   logic [AW-1:0] mem_ra, mem_wa;
   logic [RW-1:0] mem_wd;

   logic [RW-1:0] op_ff, op_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [5:0]    idx_ff, idx_in;
   logic          active_ff, active_in;
   logic [CW-1:0] rcount_ff, rcount_in;
   logic [CW-1:0] bcount_ff, bcount_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [RW-1:0] d_ff, d_in;
   logic          hit_ff, hit_in;
   logic [RW-1:0] pc_ff [4];
   logic [RW-1:0] pc_in [4];
   logic [2:0]    pcnt_ff, pcnt_in;
   logic [1:0]    pstep_ff, pstep_in;
   logic [2:0]    jcnt_ff, jcnt_in;
   logic [RW-1:0] cand_ff, cand_in;
   logic [CW-1:0] k_ff, k_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          status_ff, status_in;
   logic          found_ff, found_in;
   logic [RW-1:0] rd_ff, rd_in;

   logic [RW-1:0] rdata;
   logic [RW:0]   bmerge;
   logic [CW-1:0] rde_pos, src_pos, bld_pos;

   assign rdata   = rdsel_ff ? rdata1_ff : rdata0_ff;
   assign bmerge  = try_merge(rdata, cand_ff);
   assign rde_pos = rcount_ff - CW'(1) - CW'(idx_ff);
   assign src_pos = scan_ff - CW'(1);
   assign bld_pos = bcount_ff - CW'(1) - k_ff;

   // Status toward the controller.
   always_comb begin
      sts           = '0;
      sts.cmd_set   = (cmd_ff == CMD_SET);
      sts.cmd_bld   = (cmd_ff == CMD_SUB) || (cmd_ff == CMD_INT);
      sts.cmd_ovl   = (cmd_ff == CMD_OVL);
      sts.cmd_rde   = (cmd_ff == CMD_RDE);
      sts.is_sub    = (cmd_ff == CMD_SUB);
      sts.ovl_end   = (scan_ff == rcount_ff);
      sts.rd_hit    = overlaps(rdata, op_ff);
      sts.idx_ok    = (32'(idx_ff) < 32'(rcount_ff));
      sts.src_end   = (scan_ff == '0);
      sts.cut_last  = !hit_ff || (pstep_ff == 2'd3);
      sts.pc_end    = (jcnt_ff == '0);
      sts.add_scan  = (32'(k_ff) < 32'(MERGE_WINDOW)) && (k_ff < bcount_ff);
      sts.add_full  = (32'(bcount_ff) >= 32'(MAX_RECTS));
      sts.merge_hit = bmerge[RW];
   end

   // Next-state logic for all datapath registers and the bank ports.
   always_comb begin
      logic signed [CB-1:0] d0, d1, d2, d3, s0, s1, s2, s3;
      logic [RW-1:0]        pcand, mval;
      logic [RW:0]          mr;
      logic                 pcond, mhit;
      logic [1:0]           msel;
      logic [2:0]           pnext;

      op_in     = op_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      rcount_in = rcount_ff;
      bcount_in = bcount_ff;
      scan_in   = scan_ff;
      d_in      = d_ff;
      hit_in    = hit_ff;
      pc_in     = pc_ff;
      pcnt_in   = pcnt_ff;
      pstep_in  = pstep_ff;
      jcnt_in   = jcnt_ff;
      cand_in   = cand_ff;
      k_in      = k_ff;
      addr_in   = addr_ff;
      status_in = status_ff;
      found_in  = found_ff;
      rd_in     = rd_ff;
      mem_re    = 1'b0;
      mem_rbank = active_ff;
      mem_ra    = '0;
      mem_we    = 1'b0;
      mem_wbank = !active_ff;
      mem_wa    = '0;
      mem_wd    = cand_ff;

      d0 = crd(d_ff, 0);
      d1 = crd(d_ff, 1);
      d2 = crd(d_ff, 2);
      d3 = crd(d_ff, 3);
      s0 = crd(op_ff, 0);
      s1 = crd(op_ff, 1);
      s2 = crd(op_ff, 2);
      s3 = crd(op_ff, 3);

      pcand = d_ff;
      pcond = 1'b0;
      mhit  = 1'b0;
      msel  = '0;
      mval  = d_ff;
      mr    = '0;
      pnext = pcnt_ff;

      // Capture a command beat.
      if (cmd.load) begin
         op_in     = mk(req_x_left, req_y_top, req_x_right, req_y_bottom);
         cmd_in    = req_command;
         idx_in    = req_entry_index;
         status_in = 1'b0;
         found_in  = 1'b0;
         rd_in     = '0;
         bcount_in = '0;
         if (req_command == CMD_SUB || req_command == CMD_INT) scan_in = rcount_ff;
         else                                                  scan_in = '0;
      end

      // Set: the region becomes the operand alone.
      if (cmd.set_wr) begin
         mem_we    = 1'b1;
         mem_wbank = active_ff;
         mem_wa    = '0;
         mem_wd    = op_ff;
         rcount_in = CW'(1);
      end

      // Overlap scan from the tail upward.
      if (cmd.ovl_rd) begin
         mem_re = 1'b1;
         mem_ra = scan_ff[AW-1:0];
      end
      if (cmd.ovl_chk) begin
         if (sts.rd_hit) found_in = 1'b1;
         else            scan_in  = scan_ff + CW'(1);
      end

      // Entry read, counted from the head.
      if (cmd.rde_rd) begin
         mem_re = 1'b1;
         mem_ra = rde_pos[AW-1:0];
      end
      if (cmd.rde_ld) rd_in = rdata;

      // Walk the region from the head down.
      if (cmd.src_rd) begin
         mem_re  = 1'b1;
         mem_ra  = src_pos[AW-1:0];
         scan_in = src_pos;
      end
      if (cmd.src_ld) begin
         d_in     = rdata;
         hit_in   = sts.rd_hit;
         pcnt_in  = '0;
         pstep_in = '0;
         k_in     = '0;
         cand_in  = mk((crd(rdata, 0) > s0) ? crd(rdata, 0) : s0,
                       (crd(rdata, 1) > s1) ? crd(rdata, 1) : s1,
                       (crd(rdata, 2) < s2) ? crd(rdata, 2) : s2,
                       (crd(rdata, 3) < s3) ? crd(rdata, 3) : s3);
      end

      // One cut piece per cycle, merged into the small piece list.
      if (cmd.cut_step) begin
         pcand = d_ff;
         pcond = 1'b1;
         if (hit_ff) begin
            case (pstep_ff)
               2'd0: begin
                  pcond = (d0 < s0);
                  pcand = mk(d0, d1, CB'(s0 - 1), d3);
                  if (pcond) d_in[0 +: CB] = s0;
               end
               2'd1: begin
                  pcond = (d1 < s1);
                  pcand = mk(d0, d1, d2, CB'(s1 - 1));
                  if (pcond) d_in[CB +: CB] = s1;
               end
               2'd2: begin
                  pcond = (d2 > s2);
                  pcand = mk(CB'(s2 + 1), d1, d2, d3);
                  if (pcond) d_in[2*CB +: CB] = s2;
               end
               default: begin
                  pcond = (d3 > s3);
                  pcand = mk(d0, CB'(s3 + 1), d2, d3);
               end
            endcase
         end
         mhit = 1'b0;
         msel = '0;
         mval = pcand;
         for (int e = 0; e < 4; e++) begin
            mr = try_merge(pc_ff[e], pcand);
            if (e < int'(pcnt_ff) && (int'(pcnt_ff) - 1 - e) < MERGE_WINDOW && mr[RW]) begin
               mhit = 1'b1;
               msel = 2'(e);
               mval = mr[RW-1:0];
            end
         end
         pnext = pcnt_ff;
         if (pcond) begin
            if (mhit) begin
               pc_in[msel] = mval;
            end else if (pcnt_ff < 3'd4) begin
               pc_in[pcnt_ff[1:0]] = pcand;
               pnext = pcnt_ff + 3'd1;
            end
         end
         pcnt_in  = pnext;
         pstep_in = pstep_ff + 2'd1;
         jcnt_in  = pnext;
      end

      // Take the next piece from the head of the piece list.
      if (cmd.pc_next) begin
         cand_in = pc_ff[2'(jcnt_ff - 3'd1)];
         jcnt_in = jcnt_ff - 3'd1;
         k_in    = '0;
      end

      // Add to the build table: scan the merge window, else append, or flag overflow when full.
      if (cmd.add_rd) begin
         if (sts.add_scan) begin
            mem_re    = 1'b1;
            mem_rbank = !active_ff;
            mem_ra    = bld_pos[AW-1:0];
            addr_in   = bld_pos[AW-1:0];
         end else if (sts.add_full) begin
            status_in = 1'b1;
         end else begin
            mem_we    = 1'b1;
            mem_wa    = bcount_ff[AW-1:0];
            mem_wd    = cand_ff;
            bcount_in = bcount_ff + CW'(1);
         end
      end
      if (cmd.add_cmp) begin
         if (bmerge[RW]) begin
            mem_we = 1'b1;
            mem_wa = addr_ff;
            mem_wd = bmerge[RW-1:0];
         end else begin
            k_in = k_ff + CW'(1);
         end
      end

      // The built table becomes the region.
      if (cmd.commit) begin
         active_in = !active_ff;
         rcount_in = bcount_ff;
      end
   end

   // Table banks with registered read data.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata0_ff <= bank0_ff[mem_ra];
         rdata1_ff <= bank1_ff[mem_ra];
         rdsel_ff  <= mem_rbank;
      end
      if (mem_we && !mem_wbank) bank0_ff[mem_wa] <= mem_wd;
      if (mem_we && mem_wbank)  bank1_ff[mem_wa] <= mem_wd;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rcount_ff <= '0;
         bcount_ff <= '0;
         pcnt_ff   <= '0;
      end else begin
         active_ff <= active_in;
         rcount_ff <= rcount_in;
         bcount_ff <= bcount_in;
         pcnt_ff   <= pcnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      scan_ff   <= scan_in;
      d_ff      <= d_in;
      hit_ff    <= hit_in;
      pc_ff     <= pc_in;
      pstep_ff  <= pstep_in;
      jcnt_ff   <= jcnt_in;
      cand_ff   <= cand_in;
      k_ff      <= k_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rd_ff     <= rd_in;
   end

   // Result beat.
   assign rsp_valid         = cmd.respond;
   assign rsp_status        = status_ff;
   assign rsp_overlap_found = found_ff;
   assign rsp_region_empty  = (rcount_ff == '0);
   assign rsp_rect_count    = rcount_ff;
   assign rsp_out_x_left    = crd(rd_ff, 0);
   assign rsp_out_y_top     = crd(rd_ff, 1);
   assign rsp_out_x_right   = crd(rd_ff, 2);
   assign rsp_out_y_bottom  = crd(rd_ff, 3);

endmodule

>>> bench/clip_region_rect_engine_top_test.sv
module clip_region_rect_engine_top_test
   import crre_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  TABLE_SIZE  = 64;
   localparam int  WINDOW      = 5;
   localparam int  NUM_RANDOM  = 900;
   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam logic [2:0] CMD_SPARE   = 3'd5;
   localparam logic [2:0] CMD_SPARE_B = 3'd6;
   localparam logic [2:0] CMD_SPARE_C = 3'd7;

   typedef struct {
      longint xl;
      longint yt;
      longint xr;
      longint yb;
   } box_type;

   typedef struct {
      logic [2:0]         cmd;
      logic signed [15:0] xl;
      logic signed [15:0] yt;
      logic signed [15:0] xr;
      logic signed [15:0] yb;
      logic [5:0]         idx;
   } beat_type;

   typedef struct {
      logic               status;
      logic               found;
      logic               empty;
      logic [6:0]         count;
      logic signed [15:0] xl;
      logic signed [15:0] yt;
      logic signed [15:0] xr;
      logic signed [15:0] yb;
   } answer_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_command;
   logic signed [15:0] req_x_left, req_y_top, req_x_right, req_y_bottom;
   logic [5:0] req_entry_index;
   logic rsp_valid, rsp_status, rsp_overlap_found, rsp_region_empty;
   logic [6:0] rsp_rect_count;
   logic signed [15:0] rsp_out_x_left, rsp_out_y_top, rsp_out_x_right, rsp_out_y_bottom;

   clip_region_rect_engine_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_x_left(req_x_left), .req_y_top(req_y_top),
      .req_x_right(req_x_right), .req_y_bottom(req_y_bottom),
      .req_entry_index(req_entry_index),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_overlap_found(rsp_overlap_found), .rsp_region_empty(rsp_region_empty),
      .rsp_rect_count(rsp_rect_count), .rsp_out_x_left(rsp_out_x_left),
      .rsp_out_y_top(rsp_out_y_top), .rsp_out_x_right(rsp_out_x_right),
      .rsp_out_y_bottom(rsp_out_y_bottom)
   );

   beat_type   pending_cmds[$];
   answer_type expected_answers[$];
   box_type    region_boxes[TABLE_SIZE];
   box_type    build_boxes[TABLE_SIZE];
   box_type    piece_boxes[TABLE_SIZE];
   int      region_cnt = 0;
   int      build_cnt = 0;
   int      piece_cnt = 0;
   bit      failed = 0;
   bit      beat_taken = 0;
   int      gap_left = 0;
   longint  cycle_count = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic bit boxes_touch(box_type d, box_type s);
      return s.xr >= d.xl && s.xl <= d.xr && s.yb >= d.yt && s.yt <= d.yb;
   endfunction

   // Add at the list head (highest index), merging into the window when possible.
   function automatic bit place_box(inout box_type tab[TABLE_SIZE], inout int cnt,
                                    input int cap, input box_type b);
      int k;
      for (k = 0; k < WINDOW && k < cnt; k++) begin
         if (tab[cnt-1-k].yt == b.yt && tab[cnt-1-k].yb == b.yb) begin
            if (tab[cnt-1-k].xr + 1 == b.xl) begin
               tab[cnt-1-k].xr = b.xr;
               return 1;
            end
            if (tab[cnt-1-k].xl == b.xr + 1) begin
               tab[cnt-1-k].xl = b.xl;
               return 1;
            end
         end else if (tab[cnt-1-k].xl == b.xl && tab[cnt-1-k].xr == b.xr) begin
            if (tab[cnt-1-k].yb + 1 == b.yt) begin
               tab[cnt-1-k].yb = b.yb;
               return 1;
            end
            if (tab[cnt-1-k].yt == b.yb + 1) begin
               tab[cnt-1-k].yt = b.yt;
               return 1;
            end
         end
      end
      if (cnt >= cap) return 0;
      tab[cnt] = b;
      cnt++;
      return 1;
   endfunction

   // Split d around s into left, top, right and bottom pieces; d stays whole if they do not touch.
   function automatic void cut_box(box_type d, box_type s);
      box_type p;
      bit   ok;
      piece_cnt = 0;
      if (!boxes_touch(d, s)) begin
         ok = place_box(piece_boxes, piece_cnt, 4, d);
         return;
      end
      if (d.xl < s.xl) begin
         p = d; p.xr = s.xl - 1;
         ok = place_box(piece_boxes, piece_cnt, 4, p);
         d.xl = s.xl;
      end
      if (d.yt < s.yt) begin
         p = d; p.yb = s.yt - 1;
         ok = place_box(piece_boxes, piece_cnt, 4, p);
         d.yt = s.yt;
      end
      if (d.xr > s.xr) begin
         p = d; p.xl = s.xr + 1;
         ok = place_box(piece_boxes, piece_cnt, 4, p);
         d.xr = s.xr;
      end
      if (d.yb > s.yb) begin
         p = d; p.yt = s.yb + 1;
         ok = place_box(piece_boxes, piece_cnt, 4, p);
      end
   endfunction

   // Apply one command to the region copy and return the result it should give.
   function automatic answer_type apply_clip_command(beat_type c);
      answer_type a;
      box_type s, d, p;
      bit ok;
      int i, j;
      a = '{default: '0};
      ok = 1;
      s.xl = longint'(c.xl); s.yt = longint'(c.yt);
      s.xr = longint'(c.xr); s.yb = longint'(c.yb);
      case (c.cmd)
         CMD_SET: begin
            region_cnt = 0;
            ok = place_box(region_boxes, region_cnt, TABLE_SIZE, s);
         end
         CMD_SUB, CMD_INT: begin
            build_cnt = 0;
            for (i = region_cnt; ok && i > 0; i--) begin
               d = region_boxes[i-1];
               if (c.cmd == CMD_SUB) begin
                  cut_box(d, s);
                  for (j = piece_cnt; ok && j > 0; j--)
                     ok = place_box(build_boxes, build_cnt, TABLE_SIZE, piece_boxes[j-1]);
               end else if (boxes_touch(d, s)) begin
                  p.xl = (d.xl > s.xl) ? d.xl : s.xl;
                  p.yt = (d.yt > s.yt) ? d.yt : s.yt;
                  p.xr = (d.xr < s.xr) ? d.xr : s.xr;
                  p.yb = (d.yb < s.yb) ? d.yb : s.yb;
                  ok = place_box(build_boxes, build_cnt, TABLE_SIZE, p);
               end
            end
            if (ok) begin
               for (i = 0; i < build_cnt; i++) region_boxes[i] = build_boxes[i];
               region_cnt = build_cnt;
            end else begin
               a.status = 1;
            end
         end
         CMD_OVL: begin
            for (i = 0; i < region_cnt; i++)
               if (boxes_touch(region_boxes[i], s)) a.found = 1;
         end
         CMD_RDE: begin
            if (int'(c.idx) < region_cnt) begin
               d = region_boxes[region_cnt-1-int'(c.idx)];
               a.xl = d.xl[15:0]; a.yt = d.yt[15:0];
               a.xr = d.xr[15:0]; a.yb = d.yb[15:0];
            end
         end
         default: ;
      endcase
      a.empty = (region_cnt == 0);
      a.count = region_cnt[6:0];
      return a;
   endfunction

   // Coordinates mostly in a small window so that cuts and merges happen.
   function automatic logic signed [15:0] pick_coord(bit wide);
      if (wide) return 16'($urandom_range(0, 16'hffff));
      return 16'($urandom_range(0, 40));
   endfunction

   function automatic beat_type make_beat(logic [2:0] cmd, bit wide);
      beat_type b;
      logic signed [15:0] t;
      b.cmd = cmd;
      b.xl = pick_coord(wide); b.xr = pick_coord(wide);
      b.yt = pick_coord(wide); b.yb = pick_coord(wide);
      // Mostly well-formed boxes; a few stay inverted.
      if ($urandom_range(0, 9) != 0) begin
         if (b.xl > b.xr) begin t = b.xl; b.xl = b.xr; b.xr = t; end
         if (b.yt > b.yb) begin t = b.yt; b.yt = b.yb; b.yb = t; end
      end
      b.idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                                            6'($urandom_range(0, 12));
      return b;
   endfunction

   function automatic beat_type fixed_beat(logic [2:0] cmd, int xl, int yt, int xr, int yb,
                                           int idx);
      beat_type b;
      b.cmd = cmd; b.xl = 16'(xl); b.yt = 16'(yt); b.xr = 16'(xr); b.yb = 16'(yb);
      b.idx = 6'(idx);
      return b;
   endfunction

   // Stimulus: directed beats, then random sequences.
   initial begin
      int n, k, mode;
      beat_type b;
      reset = 1;

      pending_cmds.push_back(fixed_beat(CMD_RDE, 0, 0, 0, 0, 0));
      pending_cmds.push_back(fixed_beat(CMD_SUB, 0, 0, 5, 5, 0));
      pending_cmds.push_back(fixed_beat(CMD_SET, -32768, -32768, 32767, 32767, 0));
      pending_cmds.push_back(fixed_beat(CMD_RDE, 0, 0, 0, 0, 0));
      pending_cmds.push_back(fixed_beat(CMD_SUB, -100, -100, 100, 100, 0));
      pending_cmds.push_back(fixed_beat(CMD_RDE, 0, 0, 0, 0, 3));
      pending_cmds.push_back(fixed_beat(CMD_RDE, 0, 0, 0, 0, 63));
      pending_cmds.push_back(fixed_beat(CMD_OVL, 0, 0, 0, 0, 0));
      pending_cmds.push_back(fixed_beat(CMD_OVL, 200, 200, 300, 300, 0));
      pending_cmds.push_back(fixed_beat(CMD_INT, -32768, -32768, 0, 0, 0));
      pending_cmds.push_back(fixed_beat(CMD_RDE, 0, 0, 0, 0, 1));
      pending_cmds.push_back(fixed_beat(CMD_SPARE, 1, 2, 3, 4, 21));
      pending_cmds.push_back(fixed_beat(CMD_SPARE_B, -1, -1, -1, -1, 42));
      pending_cmds.push_back(fixed_beat(CMD_SPARE_C, 0, 0, 0, 0, 63));
      // Inverted operand, stored as given.
      pending_cmds.push_back(fixed_beat(CMD_SET, 10, 10, 5, 5, 0));
      pending_cmds.push_back(fixed_beat(CMD_RDE, 0, 0, 0, 0, 0));
      pending_cmds.push_back(fixed_beat(CMD_OVL, 6, 6, 9, 9, 0));
      pending_cmds.push_back(fixed_beat(CMD_SUB, 6, 6, 9, 9, 0));
      // Intersect with nothing left: region becomes empty.
      pending_cmds.push_back(fixed_beat(CMD_SET, 0, 0, 9, 9, 0));
      pending_cmds.push_back(fixed_beat(CMD_INT, 20, 20, 30, 30, 0));
      pending_cmds.push_back(fixed_beat(CMD_SET, 0, 0, 9, 9, 0));
      pending_cmds.push_back(fixed_beat(CMD_SUB, 0, 0, 9, 9, 0));
      pending_cmds.push_back(fixed_beat(CMD_SET, 32767, 32767, -32768, -32768, 0));
      pending_cmds.push_back(fixed_beat(CMD_INT, -32768, -32768, 32767, 32767, 0));

      n = 0;
      while (n < NUM_RANDOM) begin
         mode = $urandom_range(0, 7);
         if (mode == 0) begin
            // Punch many single-point holes to push the table past capacity.
            pending_cmds.push_back(fixed_beat(CMD_SET, 0, 0, 255, 255, 0));
            for (k = 0; k < 40; k++) begin
               b = fixed_beat(CMD_SUB, 0, 0, 0, 0, 0);
               b.xl = 16'($urandom_range(1, 254)); b.yt = 16'($urandom_range(1, 254));
               b.xr = b.xl; b.yb = b.yt;
               pending_cmds.push_back(b);
            end
            pending_cmds.push_back(make_beat(CMD_RDE, 0));
            n += 42;
         end else begin
            pending_cmds.push_back(make_beat(CMD_SET, mode == 1));
            for (k = $urandom_range(4, 14); k > 0; k--) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: b = make_beat(CMD_SUB, $urandom_range(0, 15) == 0);
                  4:          b = make_beat(CMD_INT, $urandom_range(0, 15) == 0);
                  5, 6:       b = make_beat(CMD_OVL, $urandom_range(0, 7) == 0);
                  7, 8:       b = make_beat(CMD_RDE, 0);
                  default:    b = make_beat(3'($urandom_range(0, 7)), 1);
               endcase
               pending_cmds.push_back(b);
            end
            n += 10;
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      while (pending_cmds.size() != 0 || start || expected_answers.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Driver: hold a beat until taken, then idle a random number of cycles.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_command <= CMD_SET;
         req_x_left <= '0;
         req_y_top <= '0;
         req_x_right <= '0;
         req_y_bottom <= '0;
         req_entry_index <= '0;
      end else if (start && !beat_taken) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
         beat_type b;
         b = pending_cmds.pop_front();
         req_command <= b.cmd;
         req_x_left <= b.xl;
         req_y_top <= b.yt;
         req_x_right <= b.xr;
         req_y_bottom <= b.yb;
         req_entry_index <= b.idx;
         start <= 1'b1;
         gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 5));
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: check results, then record the expectation of any beat taken.
   always @(posedge clock) begin
      beat_type   c;
      answer_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      beat_taken = 0;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: result with nothing expected", $time);
               failed = 1;
            end else begin
               e = expected_answers.pop_front();
               if (rsp_status !== e.status || rsp_overlap_found !== e.found ||
                   rsp_region_empty !== e.empty || rsp_rect_count !== e.count ||
                   rsp_out_x_left !== e.xl || rsp_out_y_top !== e.yt ||
                   rsp_out_x_right !== e.xr || rsp_out_y_bottom !== e.yb) begin
                  $display("%0t: expected st=%0d ov=%0d em=%0d n=%0d box=%0d,%0d,%0d,%0d",
                           $time, e.status, e.found, e.empty, e.count,
                           e.xl, e.yt, e.xr, e.yb);
                  $display("%0t: actual   st=%0d ov=%0d em=%0d n=%0d box=%0d,%0d,%0d,%0d",
                           $time, rsp_status, rsp_overlap_found, rsp_region_empty,
                           rsp_rect_count, rsp_out_x_left, rsp_out_y_top,
                           rsp_out_x_right, rsp_out_y_bottom);
                  failed = 1;
               end
            end
         end
         if (start && !busy) begin
            c.cmd = req_command; c.xl = req_x_left; c.yt = req_y_top;
            c.xr = req_x_right; c.yb = req_y_bottom; c.idx = req_entry_index;
            expected_answers.push_back(apply_clip_command(c));
            beat_taken = 1;
         end
      end
   end

endmodule

>>> filelist.f
src/crre_pkg.sv
src/crre_ctrl.sv
src/crre_dpath.sv
src/clip_region_rect_engine_top.sv
bench/clip_region_rect_engine_top_test.sv
